@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASSERT_ON(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/elx_pkg.sv @@
// Types, codes and keyword lookup for the expression lexer
package elx_pkg;

  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_DONE  = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  localparam logic [4:0] TK_NONE     = 5'd0;
  localparam logic [4:0] TK_IDENT    = 5'd7;
  localparam logic [4:0] TK_INT      = 5'd8;
  localparam logic [4:0] TK_TRUE     = 5'd9;
  localparam logic [4:0] TK_FALSE    = 5'd10;
  localparam logic [4:0] TK_AND      = 5'd11;
  localparam logic [4:0] TK_OR       = 5'd12;
  localparam logic [4:0] TK_XOR      = 5'd13;
  localparam logic [4:0] TK_NOT      = 5'd14;
  localparam logic [4:0] TK_IS       = 5'd15;
  localparam logic [4:0] TK_NIL      = 5'd16;
  localparam logic [4:0] TK_RESERVED = 5'd17;

  localparam logic [62:0] VALUE_MAX = {63{1'b1}};

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_IDENT = 2'd1,
    PEND_INT   = 2'd2
  } pend_t;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } elx_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [4:0]  token_kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic [62:0] integer_value;
    logic        integer_overflow;
    logic        last_of_run;
  } elx_out_t;

  typedef struct packed {
    logic [2:0]          mask;
    elx_out_t [2:0]      slot;
  } elx_bundle_t;

  // window holds character i in bits 8i+7..8i, lower case, zero padded
  function automatic logic [4:0] kw_kind(input logic [39:0] win);
    logic [39:0] rev;
    logic [4:0]  kind;
    rev = {win[7:0], win[15:8], win[23:16], win[31:24], win[39:32]};
    unique case (rev)
      {"true", 8'h00}:  kind = TK_TRUE;
      {"false"}:        kind = TK_FALSE;
      {"and", 16'h0}:   kind = TK_AND;
      {"or", 24'h0}:    kind = TK_OR;
      {"xor", 16'h0}:   kind = TK_XOR;
      {"not", 16'h0}:   kind = TK_NOT;
      {"is", 24'h0}:    kind = TK_IS;
      {"nil", 16'h0}:   kind = TK_NIL;
      {"null", 8'h00}, {"eq", 24'h0}, {"ne", 24'h0}, {"lt", 24'h0},
      {"lte", 16'h0}, {"gt", 24'h0}, {"gte", 16'h0}, {"if", 24'h0},
      {"then", 8'h00}, {"end", 16'h0}, {"for", 16'h0}, {"while"},
      {"do", 24'h0}, {"done", 8'h00}, {"in", 24'h0}, {"case", 8'h00},
      {"when", 8'h00}, {"where"}:
                        kind = TK_RESERVED;
      default:          kind = TK_IDENT;
    endcase
    return kind;
  endfunction

endpackage

@@ rtl/expression_lexer.sv @@
// Expression lexer top level: input register, step logic and result register
//
// Input channel (in_valid, in_stall, in_item): one text character per item,
// with end_of_text on the last one. Result channel (out_valid, out_stall,
// out_item): tokens, then one finished or error result closing each text.
// A character gives zero to three results; last_of_run marks the final one.
// An accepted character waits in the input register until the result register
// can be reloaded; its results are then registered and presented from there.
// Throughput: one character per cycle while each gives at most one result and
// out_stall is low; the result register sends one result a cycle when not
// stalled, so the next character waits until the last result is being taken.
// An input register lets one character be taken while results wait, so
// in_stall rises only when that register is full and the result register
// cannot be reloaded.
// After an illegal character the rest of the text up to end_of_text is
// consumed with no results. Offsets saturate at MAX_TEXT_LENGTH and are
// reported in their low 16 bits.
// Reset (rst_n low, synchronous) empties both registers and returns the
// lexer to the start of a text; a stalled result holds its value.
module expression_lexer #(
  parameter longint unsigned MAX_TEXT_LENGTH = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  elx_pkg::elx_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output elx_pkg::elx_out_t out_item
);
  import elx_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  elx_in_t     in_item_r;
  logic        load, ready;
  elx_bundle_t bundle;

  assign load     = in_vld_r && ready;
  assign in_stall = in_vld_r && !ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && !in_stall) begin
      in_vld_nxt = 1'b1;
    end else if (load) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  elx_scan #(
    .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (load),
    .item   (in_item_r),
    .bundle (bundle)
  );

  elx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .bundle    (bundle),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ rtl/elx_scan.sv @@
// Lexer state and per-character step logic, producing up to three results
module elx_scan #(
  parameter longint unsigned MAX_TEXT_LENGTH = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  elx_pkg::elx_in_t    item,
  output elx_pkg::elx_bundle_t bundle
);
  import elx_pkg::*;

  localparam int PW = $clog2(MAX_TEXT_LENGTH + 1);
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_TEXT_LENGTH);

  pend_t          pend_r, pend_nxt;
  logic [PW-1:0]  start_r, start_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [62:0]    acc_r, acc_nxt;
  logic           ovf_r, ovf_nxt;
  logic [39:0]    win_r, win_nxt;
  logic           disc_r, disc_nxt;

  logic [7:0]     c, lc;
  logic           eot;
  logic           is_letter, is_upper, is_digit, is_space, is_under, is_op;
  logic           id_first, id_rest, illegal;
  logic [2:0]     op_idx;
  logic [3:0]     dig;
  logic [PW-1:0]  p, nxt, diff;
  logic           cont_id, cont_int, cont, err;
  logic [39:0]    win_cont;
  logic [66:0]    sum;
  logic           over;
  pend_t          pend_new;
  logic [PW-1:0]  start_new;
  logic [62:0]    acc_new;
  logic           ovf_new;
  logic [39:0]    win_new;
  logic [PW-1:0]  len_a, len_b;

  function automatic logic [4:0] tok_kind(input pend_t pk, input logic [39:0] w,
                                          input logic [PW-1:0] len);
    logic [4:0] k;
    if (pk == PEND_INT) begin
      k = TK_INT;
    end else if (len == '0 || len > PW'(5)) begin
      k = TK_IDENT;
    end else begin
      k = kw_kind(w);
    end
    return k;
  endfunction

  function automatic elx_out_t flush_res(input pend_t pk, input logic [39:0] w,
                                         input logic [PW-1:0] st, input logic [PW-1:0] len,
                                         input logic [62:0] val, input logic vo);
    elx_out_t r;
    r = '0;
    r.result_kind  = RK_TOKEN;
    r.token_kind   = tok_kind(pk, w, len);
    r.token_offset = 16'(st);
    r.token_length = 16'(len);
    if (pk == PEND_INT) begin
      r.integer_value    = val;
      r.integer_overflow = vo;
    end
    return r;
  endfunction

  always_comb begin
    c        = item.character;
    eot      = item.end_of_text;
    is_upper = (c >= "A") && (c <= "Z");
    is_letter = is_upper || ((c >= "a") && (c <= "z"));
    is_digit = (c >= "0") && (c <= "9");
    is_space = (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    is_under = (c == "_");
    lc       = is_upper ? c + 8'd32 : c;
    dig      = 4'(c - "0");
    is_op    = 1'b1;
    op_idx   = 3'd0;
    unique case (c)
      "+":     op_idx = 3'd0;
      "-":     op_idx = 3'd1;
      "*":     op_idx = 3'd2;
      "/":     op_idx = 3'd3;
      "(":     op_idx = 3'd4;
      ")":     op_idx = 3'd5;
      ",":     op_idx = 3'd6;
      default: is_op = 1'b0;
    endcase
    id_first = is_under || is_letter;
    id_rest  = id_first || is_digit;
    illegal  = !(is_space || is_op || id_first || is_digit);

    p    = pos_r;
    nxt  = (p >= MAX_POS) ? MAX_POS : p + 1'b1;
    diff = p - start_r;

    cont_id  = (pend_r == PEND_IDENT) && id_rest;
    cont_int = (pend_r == PEND_INT) && is_digit;
    cont     = cont_id || cont_int;
    err      = !cont && illegal;

    win_cont = win_r;
    if (p >= start_r && diff < PW'(5)) begin
      win_cont = win_r | (40'(lc) << {diff[2:0], 3'b000});
    end
    sum  = (67'(acc_r) << 3) + (67'(acc_r) << 1) + 67'(dig);
    over = |sum[66:63];

    pend_new  = pend_r;
    start_new = start_r;
    acc_new   = acc_r;
    ovf_new   = ovf_r;
    win_new   = win_r;
    if (cont_id) begin
      win_new = win_cont;
    end else if (cont_int) begin
      acc_new = over ? VALUE_MAX : sum[62:0];
      ovf_new = ovf_r | over;
    end else begin
      pend_new = PEND_NONE;
      if (!is_space && !is_op && id_first) begin
        pend_new  = PEND_IDENT;
        start_new = p;
        win_new   = 40'(lc);
      end else if (!is_space && !is_op && is_digit) begin
        pend_new  = PEND_INT;
        start_new = p;
        acc_new   = 63'(dig);
        ovf_new   = 1'b0;
      end
    end

    len_a = (p >= start_r) ? p - start_r : '0;
    len_b = (nxt >= start_new) ? nxt - start_new : '0;

    bundle = '0;
    bundle.slot[0] = flush_res(pend_r, win_r, start_r, len_a, acc_r, ovf_r);
    bundle.mask[0] = !disc_r && !cont && (pend_r != PEND_NONE);
    if (err) begin
      bundle.slot[1].result_kind  = RK_ERROR;
      bundle.slot[1].token_kind   = TK_NONE;
      bundle.slot[1].token_offset = 16'(p);
      bundle.slot[1].token_length = 16'd1;
      bundle.mask[1] = !disc_r;
    end else if (!cont && is_op) begin
      bundle.slot[1].result_kind  = RK_TOKEN;
      bundle.slot[1].token_kind   = 5'(op_idx);
      bundle.slot[1].token_offset = 16'(p);
      bundle.slot[1].token_length = 16'd1;
      bundle.mask[1] = !disc_r;
    end else begin
      bundle.slot[1] = flush_res(pend_new, win_new, start_new, len_b, acc_new, ovf_new);
      bundle.mask[1] = !disc_r && eot && (pend_new != PEND_NONE);
    end
    bundle.slot[2].result_kind  = RK_DONE;
    bundle.slot[2].token_kind   = TK_NONE;
    bundle.slot[2].token_offset = 16'(nxt);
    bundle.mask[2] = !disc_r && eot && !err;

    pend_nxt  = pend_new;
    start_nxt = start_new;
    pos_nxt   = nxt;
    acc_nxt   = acc_new;
    ovf_nxt   = ovf_new;
    win_nxt   = win_new;
    disc_nxt  = disc_r || err;
    if (disc_r) begin
      pend_nxt  = pend_r;
      start_nxt = start_r;
      acc_nxt   = acc_r;
      ovf_nxt   = ovf_r;
      win_nxt   = win_r;
    end
    if (eot) begin
      pend_nxt  = PEND_NONE;
      start_nxt = '0;
      pos_nxt   = '0;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      win_nxt   = '0;
      disc_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= PEND_NONE;
      start_r <= '0;
      pos_r   <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      win_r   <= '0;
      disc_r  <= 1'b0;
    end else if (step) begin
      pend_r  <= pend_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      win_r   <= win_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

@@ rtl/elx_outq.sv @@
// Result register: holds one character's results and hands them out in order
module elx_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  elx_pkg::elx_bundle_t bundle,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output elx_pkg::elx_out_t    out_item
);
  import elx_pkg::*;

  logic [2:0]     mask_r, mask_nxt;
  elx_out_t [2:0] slot_r;
  logic [1:0]     sel;
  logic           take;
  logic           single;

  always_comb begin
    sel       = mask_r[0] ? 2'd0 : (mask_r[1] ? 2'd1 : 2'd2);
    single    = $onehot(mask_r);
    out_valid = |mask_r;
    take      = out_valid && !out_stall;
    ready     = !out_valid || (single && take);
    out_item  = slot_r[sel];
    out_item.last_of_run = single;
    mask_nxt  = mask_r;
    if (load) begin
      mask_nxt = bundle.mask;
    end else if (take) begin
      mask_nxt[sel] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= bundle.slot;
    end
  end

endmodule

@@ rtl/elx_checker.sv @@
// Port-level checks for the expression lexer, bound to the top level
`include "assert_macros.svh"

module elx_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input elx_pkg::elx_in_t  in_item,
  input logic              out_valid,
  input logic              out_stall,
  input elx_pkg::elx_out_t out_item
);
  import elx_pkg::*;

  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !in_stall && !out_valid, "reset left an item")

  `ASSERT_ON(a_out_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_item), "stalled item changed")

  `ASSERT_ON(a_done_last, clk, rst_n,
    out_valid && out_item.result_kind == RK_DONE |->
      out_item.last_of_run && out_item.token_length == 16'd0, "finished item not last")

  `ASSERT_ON(a_error_last, clk, rst_n,
    out_valid && out_item.result_kind == RK_ERROR |->
      out_item.last_of_run && out_item.token_length == 16'd1, "error item malformed")

  `ASSERT_ON(a_int_fields, clk, rst_n,
    out_valid && out_item.token_kind != TK_INT |->
      out_item.integer_value == '0 && !out_item.integer_overflow, "value on non-integer")

endmodule

bind expression_lexer elx_checker u_elx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
